@@ hw/rtl/sha1md_pkg.sv @@
// Shared constants, types and a helper function of the SHA-1 message digest unit.
// Used by the window, the round datapath and the top level.
// Has no dependencies of its own.
package sha1md_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned NumChain  = 5;
  localparam int unsigned WinDepth  = 16;
  localparam int unsigned NumRounds = 80;

  typedef logic [WordW-1:0] word_t;

  localparam word_t Iv [NumChain] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadMark = 8'h80;

  // Control bundle from the sequencer to the block window.
  typedef struct packed {
    logic       byte_en;
    logic [7:0] data_byte;
    logic       round_en;
    logic       expand;
  } win_ctrl_t;

  function automatic word_t rotl(word_t x, int unsigned n);
    return (x << n) | (x >> (WordW - n));
  endfunction

endpackage

@@ hw/rtl/sha1md_window.sv @@
// Sixteen-word block window of the SHA-1 unit: packs message bytes big-endian
// and produces the rolling message schedule, one word per round.
// Depends on sha1md_pkg.
module sha1md_window (
  input  logic                  clk_i,
  input  sha1md_pkg::win_ctrl_t ctrl_i,
  output sha1md_pkg::word_t     w_t_o
);

  sha1md_pkg::word_t win_q [sha1md_pkg::WinDepth];
  sha1md_pkg::word_t win_d [sha1md_pkg::WinDepth];
  sha1md_pkg::word_t w_t;

  always_comb begin
    if (ctrl_i.expand) begin
      w_t = sha1md_pkg::rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);
    end else begin
      w_t = win_q[0];
    end
  end

  always_comb begin
    win_d = win_q;
    if (ctrl_i.byte_en) begin
      for (int i = 0; i < sha1md_pkg::WinDepth - 1; i++) begin
        win_d[i] = {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_d[sha1md_pkg::WinDepth-1] = {win_q[sha1md_pkg::WinDepth-1][23:0], ctrl_i.data_byte};
    end else if (ctrl_i.round_en) begin
      for (int i = 0; i < sha1md_pkg::WinDepth - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[sha1md_pkg::WinDepth-1] = w_t;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign w_t_o = w_t;

endmodule

@@ hw/rtl/sha1md_round.sv @@
// Shared SHA-1 round datapath: round function, round constant and the
// five-operand sum that gives the new working word a.
// Depends on sha1md_pkg.
module sha1md_round (
  input  sha1md_pkg::word_t a_i,
  input  sha1md_pkg::word_t b_i,
  input  sha1md_pkg::word_t c_i,
  input  sha1md_pkg::word_t d_i,
  input  sha1md_pkg::word_t e_i,
  input  sha1md_pkg::word_t w_i,
  input  logic [6:0]        round_i,
  output sha1md_pkg::word_t a_o
);

  sha1md_pkg::word_t fv;
  sha1md_pkg::word_t k;

  always_comb begin
    if (round_i < 7'd20) begin
      fv = (b_i & c_i) | (~b_i & d_i);
      k  = sha1md_pkg::K0;
    end else if (round_i < 7'd40) begin
      fv = b_i ^ c_i ^ d_i;
      k  = sha1md_pkg::K1;
    end else if (round_i < 7'd60) begin
      fv = (b_i & c_i) | (b_i & d_i) | (c_i & d_i);
      k  = sha1md_pkg::K2;
    end else begin
      fv = b_i ^ c_i ^ d_i;
      k  = sha1md_pkg::K3;
    end
  end

  assign a_o = sha1md_pkg::rotl(a_i, 5) + fv + e_i + w_i + k;

endmodule

@@ hw/rtl/sha1_message_digest_unit.sv @@
// SHA-1 message digest unit, streaming one message byte per input transaction.
// Input channel s_axis: tdata is the message byte, tuser says the transaction
// carries a byte, tlast ends the message after any carried byte.
// Output channel m_axis: five 32-bit digest words, word 0 first, tlast on the
// fifth word.
// A byte that does not complete a 64-byte block is packed straight into the
// window. The byte that completes a block starts 80 rounds through the single
// shared round datapath, one per cycle, followed by the chaining add.
// At the end of a message the padding bytes (9 to 72 of them) go through the
// same byte path at one per cycle while no block is being compressed, each
// filled block runs the rounds and the chaining add as above, and then the
// five digest words are offered.
// s_axis_tready is high only while the unit is idle; it stays low while the
// digest waits for the receiver, and a stalled digest word holds its value.
// After the fifth word the chaining state is set to the initial constants for
// the next message. Reset does the same at once and needs no clearing pass.
// Depends on sha1md_pkg, sha1md_window and sha1md_round.
module sha1_message_digest_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tuser,   // has_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word[31:0]
  output logic        m_axis_tlast    // last_word
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRound = 5'b00010,
    StAdd   = 5'b00100,
    StPad   = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

  localparam logic [2:0] LastIdx  = 3'(sha1md_pkg::NumChain - 1);
  localparam logic [6:0] LastRnd  = 7'(sha1md_pkg::NumRounds - 1);
  localparam logic [5:0] LenPos   = 6'd56;
  localparam logic [5:0] LastPos  = 6'd63;

  state_e            state_q, state_d;
  sha1md_pkg::word_t chain_q [sha1md_pkg::NumChain];
  sha1md_pkg::word_t chain_d [sha1md_pkg::NumChain];
  sha1md_pkg::word_t work_q  [sha1md_pkg::NumChain];
  sha1md_pkg::word_t work_d  [sha1md_pkg::NumChain];
  logic [63:0]       bitcnt_q, bitcnt_d;
  logic [5:0]        pos_q, pos_d;
  logic [6:0]        round_q, round_d;
  logic [2:0]        emit_q, emit_d;
  logic              eom_q, eom_d;
  logic              mark_q, mark_d;
  logic              lenph_q, lenph_d;

  sha1md_pkg::win_ctrl_t win_ctrl;
  sha1md_pkg::word_t     w_t;
  sha1md_pkg::word_t     a_new;
  logic                  in_acc;
  logic                  out_acc;
  logic                  len_sel;
  logic [7:0]            pad_byte;
  logic                  pos_wrap;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == StEmit);
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = chain_q[emit_q];
  assign m_axis_tlast  = (emit_q == LastIdx);

  assign len_sel = lenph_q || (pos_q == LenPos);

  always_comb begin
    if (!mark_q) begin
      pad_byte = sha1md_pkg::PadMark;
    end else if (len_sel) begin
      pad_byte = 8'(bitcnt_q >> {~pos_q[2:0], 3'b000});
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    win_ctrl.byte_en   = (in_acc && s_axis_tuser) || (state_q == StPad);
    win_ctrl.data_byte = (state_q == StPad) ? pad_byte : s_axis_tdata;
    win_ctrl.round_en  = (state_q == StRound);
    win_ctrl.expand    = (round_q >= 7'd16);
  end

  assign pos_wrap = win_ctrl.byte_en && (pos_q == LastPos);

  sha1md_window u_window (
    .clk_i  (clk_i),
    .ctrl_i (win_ctrl),
    .w_t_o  (w_t)
  );

  sha1md_round u_round (
    .a_i     (work_q[0]),
    .b_i     (work_q[1]),
    .c_i     (work_q[2]),
    .d_i     (work_q[3]),
    .e_i     (work_q[4]),
    .w_i     (w_t),
    .round_i (round_q),
    .a_o     (a_new)
  );

  always_comb begin
    state_d  = state_q;
    chain_d  = chain_q;
    work_d   = work_q;
    bitcnt_d = bitcnt_q;
    pos_d    = pos_q;
    round_d  = round_q;
    emit_d   = emit_q;
    eom_d    = eom_q;
    mark_d   = mark_q;
    lenph_d  = lenph_q;
    if (win_ctrl.byte_en) begin
      pos_d = pos_q + 6'd1;
    end
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            bitcnt_d = bitcnt_q + 64'd8;
          end
          if (s_axis_tlast) begin
            eom_d = 1'b1;
          end
          if (pos_wrap) begin
            state_d = StRound;
            work_d  = chain_q;
            round_d = '0;
          end else if (s_axis_tlast) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        if (!mark_q) begin
          mark_d = 1'b1;
        end else if (len_sel) begin
          lenph_d = 1'b1;
        end
        if (pos_wrap) begin
          state_d = StRound;
          work_d  = chain_q;
          round_d = '0;
        end
      end
      StRound: begin
        work_d[0] = a_new;
        work_d[1] = work_q[0];
        work_d[2] = sha1md_pkg::rotl(work_q[1], 30);
        work_d[3] = work_q[2];
        work_d[4] = work_q[3];
        if (round_q == LastRnd) begin
          round_d = '0;
          state_d = StAdd;
        end else begin
          round_d = round_q + 7'd1;
        end
      end
      StAdd: begin
        for (int i = 0; i < sha1md_pkg::NumChain; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        if (lenph_q) begin
          state_d = StEmit;
          emit_d  = '0;
        end else if (eom_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StEmit: begin
        if (out_acc) begin
          if (emit_q == LastIdx) begin
            chain_d  = sha1md_pkg::Iv;
            bitcnt_d = '0;
            pos_d    = '0;
            emit_d   = '0;
            eom_d    = 1'b0;
            mark_d   = 1'b0;
            lenph_d  = 1'b0;
            state_d  = StIdle;
          end else begin
            emit_d = emit_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      chain_q  <= sha1md_pkg::Iv;
      bitcnt_q <= '0;
      pos_q    <= '0;
      round_q  <= '0;
      emit_q   <= '0;
      eom_q    <= 1'b0;
      mark_q   <= 1'b0;
      lenph_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      chain_q  <= chain_d;
      bitcnt_q <= bitcnt_d;
      pos_q    <= pos_d;
      round_q  <= round_d;
      emit_q   <= emit_d;
      eom_q    <= eom_d;
      mark_q   <= mark_d;
      lenph_q  <= lenph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

endmodule

@@ hw/rtl/sha1md_checker.sv @@
// Port-level checker for the SHA-1 message digest unit, with its bind.
// Sees only the top-level ports of sha1_message_digest_unit.
// Depends on nothing but the top level it is bound to.
module sha1md_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // The unit never takes a byte while a digest word is on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while digest is offered");

  // An end-of-message transaction always makes the unit busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input ready right after end of message");

  // After the final digest word the output channel goes quiet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output valid right after final digest word");

  // A stalled digest word holds its value and its last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled digest word changed");

endmodule

bind sha1_message_digest_unit sha1md_checker u_sha1md_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
